// ===== rtl/core/utf8_substring_extract_core_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 substring extract core: assertion macros
// Shared property shorthands for the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_SUBSTRING_EXTRACT_CORE_DEFINES_SVH
`define UTF8_SUBSTRING_EXTRACT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U8SS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define U8SS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/u8ss_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 substring extract package
// Byte classes, status codes and field widths of the substring core.
// ----------------------------------------------------------------------------
package u8ss_pkg;

   localparam int unsigned DATA_BITS  = 8;
   localparam int unsigned COORD_BITS = 32;

   typedef logic [DATA_BITS-1:0]  byte_type;
   typedef logic [1:0]            status_type;
   typedef logic [1:0]            pending_type;

   localparam byte_type CONT_MASK = 8'hC0;
   localparam byte_type CONT_MARK = 8'h80;
   localparam byte_type ASCII_MAX = 8'h7F;
   localparam byte_type LEAD2_LO  = 8'hC2;
   localparam byte_type LEAD2_HI  = 8'hDF;
   localparam byte_type LEAD3_LO  = 8'hE0;
   localparam byte_type LEAD3_HI  = 8'hEF;
   localparam byte_type LEAD4_LO  = 8'hF0;
   localparam byte_type LEAD4_HI  = 8'hF4;

   localparam pending_type PEND_NONE  = 2'd0;
   localparam pending_type PEND_ONE   = 2'd1;
   localparam pending_type PEND_TWO   = 2'd2;
   localparam pending_type PEND_THREE = 2'd3;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_NULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

endpackage

// ===== rtl/core/utf8_substring_extract_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 substring extract core
// Streams the bytes of one string and forwards those inside the window
// SUBSTRING(str FROM start [FOR len]), counting UTF-8 characters for text and
// bytes for binary. One transaction is taken per clock unless the result is
// stalled. Each one passes through the input register, then the result
// register, before it is presented as a result transaction. A stalled result
// holds the input register, which then holds req_ready low. The rate is set
// by the per-byte update of the position counter and the continuation
// tracker. The result for the final byte (or an empty string) carries the
// status: ok, null (malformed text, an empty string, start below one or past
// the end, negative length) or empty (zero length).
// Drop forwarded bytes of a string whose status is not ok.
// ----------------------------------------------------------------------------
`include "utf8_substring_extract_core_defines.svh"

module utf8_substring_extract_core #(
   parameter int unsigned POSITION_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                req_empty_string,
   input  logic                req_is_text,
   input  logic signed [31:0]  req_start_position,
   input  logic                req_has_length,
   input  logic signed [31:0]  req_length_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_end_of_result,
   output logic [1:0]          rsp_status
);

   localparam int unsigned CMP_BITS =
      ((POSITION_BITS > u8ss_pkg::COORD_BITS) ? POSITION_BITS : u8ss_pkg::COORD_BITS) + 1;
   localparam int unsigned MAG_BITS = u8ss_pkg::COORD_BITS - 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

   // input register
   logic                             in_valid_ff;
   u8ss_pkg::byte_type               in_data_ff;
   logic                             in_last_ff;
   logic                             in_empty_ff;
   logic                             in_text_ff;
   logic [u8ss_pkg::COORD_BITS-1:0]  in_start_ff;
   logic                             in_has_len_ff;
   logic [u8ss_pkg::COORD_BITS-1:0]  in_len_ff;

   // string state
   logic [POSITION_BITS-1:0]         pos_ff, pos_in;
   u8ss_pkg::pending_type            pend_ff, pend_in;
   logic                             mal_ff, mal_in;

   // result register
   logic                             rsp_valid_ff;
   u8ss_pkg::byte_type               rsp_byte_ff, rsp_byte_in;
   logic                             rsp_bvalid_ff, rsp_bvalid_in;
   logic                             rsp_end_ff, rsp_end_in;
   u8ss_pkg::status_type             rsp_status_ff, rsp_status_in;

   logic                             advance;
   logic                             is_cont;
   logic                             new_char;
   logic                             start_ok;
   logic                             len_pos;
   logic                             len_neg;
   logic                             len_zero;
   logic                             final_mal;
   logic [CMP_BITS-1:0]              pos_ext;
   logic [CMP_BITS-1:0]              start_ext;
   logic [CMP_BITS-1:0]              end_ext;
   logic                             reached;
   logic                             in_window;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff    <= req_data_byte;
         in_last_ff    <= req_last_byte;
         in_empty_ff   <= req_empty_string;
         in_text_ff    <= req_is_text;
         in_start_ff   <= req_start_position;
         in_has_len_ff <= req_has_length;
         in_len_ff     <= req_length_count;
      end
   end

   always_comb begin
      is_cont  = (in_data_ff & u8ss_pkg::CONT_MASK) == u8ss_pkg::CONT_MARK;
      new_char = 1'b1;
      pend_in  = pend_ff;
      mal_in   = mal_ff;
      if (in_text_ff) begin
         if (pend_ff != u8ss_pkg::PEND_NONE && is_cont) begin
            pend_in  = pend_ff - u8ss_pkg::PEND_ONE;
            new_char = 1'b0;
         end else begin
            if (pend_ff != u8ss_pkg::PEND_NONE) begin
               mal_in = 1'b1;
            end
            if (in_data_ff <= u8ss_pkg::ASCII_MAX) begin
               pend_in = u8ss_pkg::PEND_NONE;
            end else if (in_data_ff >= u8ss_pkg::LEAD2_LO && in_data_ff <= u8ss_pkg::LEAD2_HI) begin
               pend_in = u8ss_pkg::PEND_ONE;
            end else if (in_data_ff >= u8ss_pkg::LEAD3_LO && in_data_ff <= u8ss_pkg::LEAD3_HI) begin
               pend_in = u8ss_pkg::PEND_TWO;
            end else if (in_data_ff >= u8ss_pkg::LEAD4_LO && in_data_ff <= u8ss_pkg::LEAD4_HI) begin
               pend_in = u8ss_pkg::PEND_THREE;
            end else begin
               pend_in = u8ss_pkg::PEND_NONE;
               mal_in  = 1'b1;
            end
         end
      end else begin
         pend_in = u8ss_pkg::PEND_NONE;
      end
      pos_in = (new_char && pos_ff != POS_MAX) ? pos_ff + POS_ONE : pos_ff;
   end

   always_comb begin
      start_ok  = !in_start_ff[MAG_BITS] && (in_start_ff[MAG_BITS-1:0] != '0);
      len_neg   = in_len_ff[MAG_BITS];
      len_zero  = in_len_ff == '0;
      len_pos   = !len_neg && !len_zero;
      pos_ext   = {{(CMP_BITS-POSITION_BITS){1'b0}}, pos_in};
      start_ext = {{(CMP_BITS-MAG_BITS){1'b0}}, in_start_ff[MAG_BITS-1:0]};
      end_ext   = start_ext + {{(CMP_BITS-MAG_BITS){1'b0}}, in_len_ff[MAG_BITS-1:0]};
      reached   = pos_ext >= start_ext;
      in_window = start_ok && reached && (!in_has_len_ff || (len_pos && pos_ext < end_ext));
      final_mal = mal_in || (pend_in != u8ss_pkg::PEND_NONE);

      if (in_empty_ff) begin
         rsp_byte_in   = '0;
         rsp_bvalid_in = 1'b0;
         rsp_end_in    = 1'b1;
         rsp_status_in = u8ss_pkg::STATUS_NULL;
      end else begin
         rsp_byte_in   = in_window ? in_data_ff : '0;
         rsp_bvalid_in = in_window;
         rsp_end_in    = in_last_ff;
         rsp_status_in = u8ss_pkg::STATUS_OK;
         if (in_last_ff) begin
            if ((in_text_ff && final_mal) || !start_ok || !reached ||
                (in_has_len_ff && len_neg)) begin
               rsp_status_in = u8ss_pkg::STATUS_NULL;
            end else if (in_has_len_ff && len_zero) begin
               rsp_status_in = u8ss_pkg::STATUS_EMPTY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         pend_ff <= u8ss_pkg::PEND_NONE;
         mal_ff  <= 1'b0;
      end else if (advance) begin
         if (in_empty_ff || in_last_ff) begin
            pos_ff  <= '0;
            pend_ff <= u8ss_pkg::PEND_NONE;
            mal_ff  <= 1'b0;
         end else begin
            pos_ff  <= pos_in;
            pend_ff <= pend_in;
            mal_ff  <= mal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_bvalid_ff <= rsp_bvalid_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_byte_valid    = rsp_bvalid_ff;
   assign rsp_end_of_result = rsp_end_ff;
   assign rsp_status        = rsp_status_ff;

   `U8SS_ASSERT_IMPLY(a_status_only_at_end, clock, reset,
      rsp_valid_ff && rsp_status_ff != u8ss_pkg::STATUS_OK, rsp_end_ff,
      "status set on a result that is not the end of the string")

   `U8SS_ASSERT_IMPLY(a_dropped_byte_zero, clock, reset,
      rsp_valid_ff && !rsp_bvalid_ff, rsp_byte_ff == '0,
      "byte outside the window is not zero")

   `U8SS_ASSERT_NEXT(a_state_cleared, clock, reset,
      advance && (in_empty_ff || in_last_ff),
      pos_ff == '0 && pend_ff == u8ss_pkg::PEND_NONE && !mal_ff,
      "string state not cleared after the final transaction")

   `U8SS_ASSERT_IMPLY(a_stall_only_when_full, clock, reset,
      !req_ready, in_valid_ff && rsp_valid_ff && !rsp_ready,
      "input stalled while the pipeline can advance")

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// UTF-8 substring extract core testbench
// Streams strings through the core, one byte per transaction: a short table of
// directed bytes (empty string, window extremes, bad lead bytes, multibyte
// characters), then random text and binary strings, mostly well-formed, some
// with invalid, missing or cut-off characters. Every result transaction is
// compared with its table row's typed result or with a model of the window,
// position count and UTF-8 tracking. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      u8ss_pkg::byte_type data;
      logic               last;
      logic               empty;
      logic               text;
      logic signed [31:0] start;
      logic               has_len;
      logic signed [31:0] len;
   } substr_req_type;

   typedef struct packed {
      u8ss_pkg::byte_type   data;
      logic                 in_window;
      logic                 end_flag;
      u8ss_pkg::status_type status;
   } substr_rsp_type;

   typedef struct packed {
      substr_req_type req;
      logic           typed;
      substr_rsp_type rsp;
   } directed_row_type;

   typedef enum {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} pace_type;

   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
   localparam u8ss_pkg::status_type S_OK    = u8ss_pkg::STATUS_OK;
   localparam u8ss_pkg::status_type S_NULL  = u8ss_pkg::STATUS_NULL;
   localparam u8ss_pkg::status_type S_EMPTY = u8ss_pkg::STATUS_EMPTY;
   localparam int NUM_DIRECTED    = 26;
   localparam int RANDOM_ITEMS    = 400;
   localparam int PRESSURE_STRING = 20;

   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{'{8'h00,1'b1,1'b1,1'b0,32'sd1,1'b0,32'sd0},1'b1,'{8'h00,1'b0,1'b1,S_NULL}},
      '{'{8'h41,1'b1,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b1,'{8'h41,1'b1,1'b1,S_OK}},
      '{'{8'hFF,1'b1,1'b0,1'b0,32'sd1,1'b1,32'sd0},1'b1,'{8'h00,1'b0,1'b1,S_EMPTY}},
      '{'{8'h00,1'b1,1'b0,1'b0,32'sd0,1'b0,32'sd0},1'b1,'{8'h00,1'b0,1'b1,S_NULL}},
      '{'{8'h80,1'b1,1'b0,1'b0,POS_MAX,1'b0,32'sd0},1'b1,'{8'h00,1'b0,1'b1,S_NULL}},
      '{'{8'h7F,1'b1,1'b0,1'b0,POS_MIN,1'b0,32'sd0},1'b1,'{8'h00,1'b0,1'b1,S_NULL}},
      '{'{8'hAA,1'b1,1'b0,1'b0,32'sd1,1'b1,-32'sd1},1'b1,'{8'h00,1'b0,1'b1,S_NULL}},
      '{'{8'h55,1'b1,1'b0,1'b0,32'sd1,1'b1,POS_MAX},1'b1,'{8'h55,1'b1,1'b1,S_OK}},
      '{'{8'hC0,1'b1,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b1,'{8'hC0,1'b1,1'b1,S_NULL}},
      '{'{8'h80,1'b1,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b1,'{8'h80,1'b1,1'b1,S_NULL}},
      '{'{8'hF5,1'b1,1'b0,1'b1,32'sd1,1'b1,POS_MIN},1'b1,'{8'h00,1'b0,1'b1,S_NULL}},
      '{'{8'hC3,1'b0,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b0,'0},
      '{'{8'hA9,1'b1,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b0,'0},
      '{'{8'hE2,1'b0,1'b0,1'b1,32'sd1,1'b1,32'sd1},1'b0,'0},
      '{'{8'h82,1'b0,1'b0,1'b1,32'sd1,1'b1,32'sd1},1'b0,'0},
      '{'{8'hAC,1'b1,1'b0,1'b1,32'sd1,1'b1,32'sd1},1'b0,'0},
      '{'{8'h61,1'b0,1'b0,1'b1,32'sd2,1'b1,32'sd1},1'b0,'0},
      '{'{8'hF0,1'b0,1'b0,1'b1,32'sd2,1'b1,32'sd1},1'b0,'0},
      '{'{8'h9F,1'b0,1'b0,1'b1,32'sd2,1'b1,32'sd1},1'b0,'0},
      '{'{8'h98,1'b0,1'b0,1'b1,32'sd2,1'b1,32'sd1},1'b0,'0},
      '{'{8'h80,1'b0,1'b0,1'b1,32'sd2,1'b1,32'sd1},1'b0,'0},
      '{'{8'h62,1'b1,1'b0,1'b1,32'sd2,1'b1,32'sd1},1'b0,'0},
      '{'{8'hC3,1'b0,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b0,'0},
      '{'{8'h41,1'b1,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b0,'0},
      '{'{8'hE2,1'b0,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b0,'0},
      '{'{8'h82,1'b1,1'b0,1'b1,32'sd1,1'b0,32'sd0},1'b0,'0}
   };

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_ready;
   u8ss_pkg::byte_type   req_data_byte;
   logic                 req_last_byte;
   logic                 req_empty_string;
   logic                 req_is_text;
   logic signed [31:0]   req_start_position;
   logic                 req_has_length;
   logic signed [31:0]   req_length_count;
   logic                 rsp_valid;
   logic                 rsp_ready;
   u8ss_pkg::byte_type   rsp_out_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_end_of_result;
   u8ss_pkg::status_type rsp_status;

   logic [31:0]           char_count;
   u8ss_pkg::pending_type cont_left;
   logic                  bad_utf8;

   substr_rsp_type expected_results [$];
   int             error_count;
   int             items_sent;
   pace_type       send_pace;
   int             send_pace_left;
   pace_type       take_pace;
   int             take_pace_left;

   utf8_substring_extract_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_empty_string   (req_empty_string),
      .req_is_text        (req_is_text),
      .req_start_position (req_start_position),
      .req_has_length     (req_has_length),
      .req_length_count   (req_length_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_result  (rsp_end_of_result),
      .rsp_status         (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic int draw_wait(inout pace_type pace, inout int pace_left);
      if (pace_left == 0) begin
         pace = pace_type'($urandom_range(0, 2));
         pace_left = $urandom_range(10, 60);
      end
      pace_left--;
      case (pace)
         PACE_STEADY: return 0;
         PACE_LIGHT:  return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
         default:     return $urandom_range(0, 17);
      endcase
   endfunction

   function automatic substr_rsp_type predict_substring(input substr_req_type it);
      substr_rsp_type r;
      logic           new_char;
      logic [63:0]    pos;
      r = '0;
      if (it.empty) begin
         char_count = '0;
         cont_left = u8ss_pkg::PEND_NONE;
         bad_utf8 = 1'b0;
         r.end_flag = 1'b1;
         r.status = u8ss_pkg::STATUS_NULL;
         return r;
      end
      new_char = 1'b1;
      if (!it.text) begin
         cont_left = u8ss_pkg::PEND_NONE;
      end else if (cont_left != u8ss_pkg::PEND_NONE &&
                   (it.data & u8ss_pkg::CONT_MASK) == u8ss_pkg::CONT_MARK) begin
         cont_left = cont_left - u8ss_pkg::PEND_ONE;
         new_char = 1'b0;
      end else begin
         if (cont_left != u8ss_pkg::PEND_NONE) bad_utf8 = 1'b1;
         cont_left = u8ss_pkg::PEND_NONE;
         if (it.data <= u8ss_pkg::ASCII_MAX) begin
            cont_left = u8ss_pkg::PEND_NONE;
         end else if (it.data >= u8ss_pkg::LEAD2_LO && it.data <= u8ss_pkg::LEAD2_HI) begin
            cont_left = u8ss_pkg::PEND_ONE;
         end else if (it.data >= u8ss_pkg::LEAD3_LO && it.data <= u8ss_pkg::LEAD3_HI) begin
            cont_left = u8ss_pkg::PEND_TWO;
         end else if (it.data >= u8ss_pkg::LEAD4_LO && it.data <= u8ss_pkg::LEAD4_HI) begin
            cont_left = u8ss_pkg::PEND_THREE;
         end else begin
            bad_utf8 = 1'b1;
         end
      end
      if (new_char && char_count != '1) char_count++;
      pos = 64'(char_count);
      if (it.start >= 1 && pos >= 64'(it.start)) begin
         if (!it.has_len) begin
            r.in_window = 1'b1;
         end else if (it.len > 0 && pos < 64'(it.start) + 64'(it.len)) begin
            r.in_window = 1'b1;
         end
      end
      r.data = r.in_window ? it.data : '0;
      r.end_flag = it.last;
      r.status = u8ss_pkg::STATUS_OK;
      if (it.last) begin
         if (it.text && cont_left != u8ss_pkg::PEND_NONE) bad_utf8 = 1'b1;
         if ((it.text && bad_utf8) || it.start < 1 || pos < 64'(it.start) ||
             (it.has_len && it.len < 0)) begin
            r.status = u8ss_pkg::STATUS_NULL;
         end else if (it.has_len && it.len == 0) begin
            r.status = u8ss_pkg::STATUS_EMPTY;
         end
         char_count = '0;
         cont_left = u8ss_pkg::PEND_NONE;
         bad_utf8 = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   task automatic drive_item(input substr_req_type it, input logic typed,
                             input substr_rsp_type typed_rsp);
      int             gap;
      substr_rsp_type predicted;
      gap = draw_wait(send_pace, send_pace_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= it.data;
      req_last_byte      <= it.last;
      req_empty_string   <= it.empty;
      req_is_text        <= it.text;
      req_start_position <= it.start;
      req_has_length     <= it.has_len;
      req_length_count   <= it.len;
      do @(posedge clock); while (!req_ready);
      predicted = predict_substring(it);
      expected_results.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic check_result();
      substr_rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result transaction with no byte outstanding");
         return;
      end
      want = expected_results.pop_front();
      if (rsp_out_byte !== want.data)
         report_mismatch($sformatf("out_byte %h, expected %h", rsp_out_byte, want.data));
      if (rsp_byte_valid !== want.in_window)
         report_mismatch($sformatf("byte_valid %b, expected %b", rsp_byte_valid, want.in_window));
      if (rsp_end_of_result !== want.end_flag)
         report_mismatch($sformatf("end_of_result %b, expected %b",
                                   rsp_end_of_result, want.end_flag));
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      take_pace_left = 0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(take_pace, take_pace_left);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_result();
      end
   end

   initial begin
      substr_req_type     it;
      u8ss_pkg::byte_type bytes [$];
      int                 nchars;
      int                 span;
      int                 width;
      int                 string_count;
      logic               text;
      logic signed [31:0] start;
      logic               has_len;
      logic signed [31:0] len;

      req_valid          <= 1'b0;
      req_data_byte      <= '0;
      req_last_byte      <= 1'b0;
      req_empty_string   <= 1'b0;
      req_is_text        <= 1'b0;
      req_start_position <= '0;
      req_has_length     <= 1'b0;
      req_length_count   <= '0;
      char_count = '0;
      cont_left = u8ss_pkg::PEND_NONE;
      bad_utf8 = 1'b0;
      error_count = 0;
      items_sent = 0;
      send_pace_left = 0;
      string_count = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         drive_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);
      drain_results();

      while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
         string_count++;
         if (string_count == PRESSURE_STRING) drain_results();

         text = ($urandom_range(0, 3) != 0);
         nchars = $urandom_range(1, 8);
         span = nchars + 2;
         case ($urandom_range(0, 9))
            0:       start = $urandom;
            1:       start = -int'($urandom_range(0, 3));
            2:       start = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
            default: start = $urandom_range(1, span);
         endcase
         has_len = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0:       len = $urandom;
            1:       len = -int'($urandom_range(1, 3));
            2:       len = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
            3:       len = 0;
            default: len = $urandom_range(1, span);
         endcase

         if ($urandom_range(0, 15) == 0) begin
            it = '{data: u8ss_pkg::byte_type'($urandom), last: 1'($urandom_range(0, 1)),
                   empty: 1'b1, text: text, start: start, has_len: has_len, len: len};
            drive_item(it, 1'b0, '0);
            continue;
         end

         bytes.delete();
         for (int k = 0; k < nchars; k++) begin
            if (!text) begin
               bytes.push_back(u8ss_pkg::byte_type'($urandom_range(0, 255)));
            end else begin
               width = $urandom_range(1, 4);
               case (width)
                  1: bytes.push_back(u8ss_pkg::byte_type'(
                        $urandom_range(0, u8ss_pkg::ASCII_MAX)));
                  2: bytes.push_back(u8ss_pkg::byte_type'(
                        $urandom_range(u8ss_pkg::LEAD2_LO, u8ss_pkg::LEAD2_HI)));
                  3: bytes.push_back(u8ss_pkg::byte_type'(
                        $urandom_range(u8ss_pkg::LEAD3_LO, u8ss_pkg::LEAD3_HI)));
                  default: bytes.push_back(u8ss_pkg::byte_type'(
                        $urandom_range(u8ss_pkg::LEAD4_LO, u8ss_pkg::LEAD4_HI)));
               endcase
               for (int m = 1; m < width; m++)
                  bytes.push_back(u8ss_pkg::byte_type'($urandom_range(
                     u8ss_pkg::CONT_MARK, u8ss_pkg::CONT_MARK | ~u8ss_pkg::CONT_MASK)));
            end
         end

         if (text && $urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
               0: bytes[$urandom_range(0, bytes.size() - 1)] = $urandom_range(0, 1) ?
                     u8ss_pkg::byte_type'($urandom_range(u8ss_pkg::CONT_MARK,
                                                         u8ss_pkg::LEAD2_LO - 1)) :
                     u8ss_pkg::byte_type'($urandom_range(u8ss_pkg::LEAD4_HI + 1, 8'hFF));
               1: bytes.insert($urandom_range(1, bytes.size()),
                               u8ss_pkg::byte_type'($urandom_range(0, u8ss_pkg::ASCII_MAX)));
               default: bytes.push_back(u8ss_pkg::byte_type'(
                           $urandom_range(u8ss_pkg::LEAD2_LO, u8ss_pkg::LEAD4_HI)));
            endcase
         end

         for (int k = 0; k < bytes.size(); k++) begin
            if ($urandom_range(0, 39) == 0) begin
               it = '{data: u8ss_pkg::byte_type'($urandom), last: 1'($urandom_range(0, 1)),
                      empty: 1'b1, text: text, start: start, has_len: has_len, len: len};
               drive_item(it, 1'b0, '0);
            end
            it = '{data: bytes[k], last: (k == bytes.size() - 1), empty: 1'b0,
                   text: text, start: start, has_len: has_len, len: len};
            drive_item(it, 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
